// ----- src/bounded_max_heap_top_k_top_assert.svh -----
// ----------------------------------------------------------------------------
// bounded max-heap top-k: assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_MAX_HEAP_TOP_K_TOP_ASSERT_SVH
`define BOUNDED_MAX_HEAP_TOP_K_TOP_ASSERT_SVH

// property holds at every clock edge out of reset
`define BMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define BMH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- src/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmh_pkg
// Widths, codes and the command/status types shared by the top-k heap.
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

  localparam int MAX_NEIGHBOURS = 16;
  localparam int SLOT_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int KID_W  = SLOT_W + 2;

  localparam int KIND_W = 2;
  localparam int DIST_W = 32;
  localparam int REC_W  = 16;
  localparam int STAT_W = 3;
  localparam int FILL_W = 5;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_UP_START,
    OP_RD_PARENT,
    OP_UP_MOVE,
    OP_PLACE,
    OP_RD_ROOT,
    OP_REPLACE,
    OP_RD_POP,
    OP_POP_TAKE,
    OP_RD_KIDS,
    OP_DN_MOVE,
    OP_CLEAR
  } dp_op_e;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [REC_W-1:0]  rec;
  } entry_t;

  typedef struct packed {
    dp_op_e  op;
    logic    set_status;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  empty;
    logic  pos_zero;
    logic  up_gt;
    logic  root_lt;
    logic  dn_move;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/bmh_in_if.sv -----
// ----------------------------------------------------------------------------
// bmh_in_if
// Operation channel: kind, candidate distance and record index.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmh_in_if;
  logic                        valid;
  logic                        ready;
  logic [bmh_pkg::KIND_W-1:0]  kind;
  logic [bmh_pkg::DIST_W-1:0]  distance;
  logic [bmh_pkg::REC_W-1:0]   record_index;

  modport source (output valid, kind, distance, record_index, input ready);
  modport sink   (input valid, kind, distance, record_index, output ready);
endinterface

`default_nettype wire

// ----- src/bmh_out_if.sv -----
// ----------------------------------------------------------------------------
// bmh_out_if
// Result channel: status, popped entry and fill level.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmh_out_if;
  logic                        valid;
  logic                        ready;
  logic [bmh_pkg::STAT_W-1:0]  status;
  logic [bmh_pkg::DIST_W-1:0]  out_distance;
  logic [bmh_pkg::REC_W-1:0]   out_record;
  logic [bmh_pkg::FILL_W-1:0]  fill_level;

  modport source (output valid, status, out_distance, out_record, fill_level, input ready);
  modport sink   (input valid, status, out_distance, out_record, fill_level, output ready);
endinterface

`default_nettype wire

// ----- src/bmh_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bmh_cfg_if
// Configuration write channel for the heap capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmh_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bmh_pkg::CFG_W-1:0]  neighbour_count;

  modport source (output valid, neighbour_count, input ready);
  modport sink   (input valid, neighbour_count, output ready);
endinterface

`default_nettype wire

// ----- src/bounded_max_heap_top_k_top.sv -----
// ----------------------------------------------------------------------------
// bounded_max_heap_top_k_top
// Bounded max-heap keeping the k smallest distances with their record ids.
// ----------------------------------------------------------------------------
//  channel   dir   what it carries
//  item_i    in    kind, distance, record_index
//  result_o  out   status, out_distance, out_record, fill_level
//  cfg_i     in    neighbour_count (heap capacity), always ready
//
//  one item at a time; each heap level costs a memory read state and a
//  compare/write state, and an item is done only once its result beat
//  has been taken.
//  reset empties the heap and sets capacity to 16; slots are not cleared.
//  no new item is taken until the pending result beat has gone out.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_max_heap_top_k_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  bmh_in_if.sink       item_i,
  bmh_out_if.source    result_o,
  bmh_cfg_if.sink      cfg_i
);

  bmh_pkg::dp_cmd_t  cmd;
  bmh_pkg::dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  bmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bmh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (item_i.kind),
    .distance_i     (item_i.distance),
    .record_index_i (item_i.record_index),
    .cfg_we_i       (cfg_i.valid),
    .cfg_data_i     (cfg_i.neighbour_count),
    .status_o       (result_o.status),
    .out_distance_o (result_o.out_distance),
    .out_record_o   (result_o.out_record),
    .fill_level_o   (result_o.fill_level)
  );

`include "bounded_max_heap_top_k_top_assert.svh"

  `BMH_NEVER(a_no_accept_while_result, item_i.valid && item_i.ready && result_o.valid, "item beat taken while result pending")
  `BMH_NEVER(a_fill_in_range, 32'(result_o.fill_level) > 32'(bmh_pkg::MAX_NEIGHBOURS), "fill level above slot count")
  `BMH_ASSERT(a_insert_nonempty, result_o.valid && (result_o.status == bmh_pkg::ST_INSERTED) |-> (result_o.fill_level != '0), "insert reported with empty heap")
  `BMH_ASSERT(a_result_follows_item, (item_i.valid && item_i.ready) |=> !result_o.valid, "result beat too early after item beat")

endmodule

`default_nettype wire

// ----- src/bmh_datapath.sv -----
// ----------------------------------------------------------------------------
// bmh_datapath
// Heap slot memory, carried entry, position and fill count, capacity register
// and the result registers; executes one command from the controller a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  bmh_pkg::dp_cmd_t             cmd_i,
  output bmh_pkg::dp_stat_t            stat_o,
  input  wire [bmh_pkg::KIND_W-1:0]    kind_i,
  input  wire [bmh_pkg::DIST_W-1:0]    distance_i,
  input  wire [bmh_pkg::REC_W-1:0]     record_index_i,
  input  wire                          cfg_we_i,
  input  wire [bmh_pkg::CFG_W-1:0]     cfg_data_i,
  output logic [bmh_pkg::STAT_W-1:0]   status_o,
  output logic [bmh_pkg::DIST_W-1:0]   out_distance_o,
  output logic [bmh_pkg::REC_W-1:0]    out_record_o,
  output logic [bmh_pkg::FILL_W-1:0]   fill_level_o
);

  bmh_pkg::entry_t mem_q [bmh_pkg::MAX_NEIGHBOURS];
  bmh_pkg::entry_t rd_a_q, rd_b_q, cur_q, cur_d, wr_data;
  logic [bmh_pkg::SLOT_W-1:0] raddr_a, raddr_b, pos_q, pos_d, parent, child;
  logic [bmh_pkg::CNT_W-1:0]  count_q, count_d, cap;
  logic [bmh_pkg::CFG_W-1:0]  cfg_q;
  logic [bmh_pkg::KIND_W-1:0] kind_q;
  logic [bmh_pkg::DIST_W-1:0] dist_q, odist_q, odist_d;
  logic [bmh_pkg::REC_W-1:0]  rec_q, orec_q, orec_d;
  bmh_pkg::status_e           status_q;
  logic [bmh_pkg::KID_W-1:0]  left, right, count_ext;
  logic                       we, left_big, pick_right;
  logic [bmh_pkg::DIST_W-1:0] big_dist;

  // capacity clamp: zero acts as one, above the slot count acts as full size
  always_comb begin
    if (cfg_q == '0) begin
      cap = bmh_pkg::CNT_W'(1);
    end else if (32'(cfg_q) > 32'(bmh_pkg::MAX_NEIGHBOURS)) begin
      cap = bmh_pkg::CNT_W'(bmh_pkg::MAX_NEIGHBOURS);
    end else begin
      cap = bmh_pkg::CNT_W'(cfg_q);
    end
  end

  assign parent    = bmh_pkg::SLOT_W'((pos_q - bmh_pkg::SLOT_W'(1)) >> 1);
  assign left      = bmh_pkg::KID_W'({pos_q, 1'b1});
  assign right     = left + bmh_pkg::KID_W'(1);
  assign count_ext = bmh_pkg::KID_W'(count_q);

  // pick the larger child; ties keep the carried entry, then the left child
  assign left_big   = (left < count_ext) && (rd_a_q.distance > cur_q.distance);
  assign big_dist   = left_big ? rd_a_q.distance : cur_q.distance;
  assign pick_right = (right < count_ext) && (rd_b_q.distance > big_dist);
  assign child      = pick_right ? bmh_pkg::SLOT_W'(right) : bmh_pkg::SLOT_W'(left);

  always_comb begin
    stat_o.kind     = bmh_pkg::kind_e'(kind_q);
    stat_o.full     = (count_q >= cap);
    stat_o.empty    = (count_q == '0);
    stat_o.pos_zero = (pos_q == '0);
    stat_o.up_gt    = (cur_q.distance > rd_a_q.distance);
    stat_o.root_lt  = (dist_q < rd_a_q.distance);
    stat_o.dn_move  = left_big || pick_right;
  end

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    we      = 1'b0;
    wr_data = cur_q;
    cur_d   = cur_q;
    pos_d   = pos_q;
    count_d = count_q;
    odist_d = odist_q;
    orec_d  = orec_q;
    case (cmd_i.op)
      bmh_pkg::OP_LOAD: begin
        odist_d = '0;
        orec_d  = '0;
      end
      bmh_pkg::OP_UP_START: begin
        cur_d   = '{distance: dist_q, rec: rec_q};
        pos_d   = bmh_pkg::SLOT_W'(count_q);
        count_d = count_q + bmh_pkg::CNT_W'(1);
      end
      bmh_pkg::OP_RD_PARENT: raddr_a = parent;
      bmh_pkg::OP_UP_MOVE: begin
        we      = 1'b1;
        wr_data = rd_a_q;
        pos_d   = parent;
      end
      bmh_pkg::OP_PLACE: we = 1'b1;
      bmh_pkg::OP_RD_ROOT: raddr_a = '0;
      bmh_pkg::OP_REPLACE: begin
        cur_d = '{distance: dist_q, rec: rec_q};
        pos_d = '0;
      end
      bmh_pkg::OP_RD_POP: begin
        raddr_a = '0;
        raddr_b = bmh_pkg::SLOT_W'(count_q - bmh_pkg::CNT_W'(1));
      end
      bmh_pkg::OP_POP_TAKE: begin
        odist_d = rd_a_q.distance;
        orec_d  = rd_a_q.rec;
        cur_d   = rd_b_q;
        count_d = count_q - bmh_pkg::CNT_W'(1);
        pos_d   = '0;
      end
      bmh_pkg::OP_RD_KIDS: begin
        raddr_a = bmh_pkg::SLOT_W'(left);
        raddr_b = bmh_pkg::SLOT_W'(right);
      end
      bmh_pkg::OP_DN_MOVE: begin
        we      = 1'b1;
        wr_data = pick_right ? rd_b_q : rd_a_q;
        pos_d   = child;
      end
      bmh_pkg::OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  // slot memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[pos_q] <= wr_data;
    end
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cfg_q   <= bmh_pkg::CFG_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    pos_q   <= pos_d;
    odist_q <= odist_d;
    orec_q  <= orec_d;
    if (cmd_i.op == bmh_pkg::OP_LOAD) begin
      kind_q <= kind_i;
      dist_q <= distance_i;
      rec_q  <= record_index_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  assign status_o       = status_q;
  assign out_distance_o = odist_q;
  assign out_record_o   = orec_q;
  assign fill_level_o   = bmh_pkg::FILL_W'(count_q);

endmodule

`default_nettype wire

// ----- src/bmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmh_ctrl
// Sequencer for one heap operation: dispatch on kind, walk the sift up or
// sift down one level per read/compare pair, then hold the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  bmh_pkg::dp_stat_t   stat_i,
  output bmh_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISP     = 9'b000000010,
    S_UP_RD    = 9'b000000100,
    S_UP_CMP   = 9'b000001000,
    S_ROOT_CMP = 9'b000010000,
    S_POP_TAKE = 9'b000100000,
    S_DN_RD    = 9'b001000000,
    S_DN_CMP   = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    cmd_o.op          = bmh_pkg::OP_NONE;
    cmd_o.set_status  = 1'b0;
    cmd_o.status      = bmh_pkg::ST_REJECTED;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = bmh_pkg::OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.set_status = 1'b1;
        unique case (stat_i.kind)
          bmh_pkg::KIND_PUSH: begin
            if (!stat_i.full) begin
              cmd_o.op     = bmh_pkg::OP_UP_START;
              cmd_o.status = bmh_pkg::ST_INSERTED;
              state_d      = S_UP_RD;
            end else begin
              cmd_o.op = bmh_pkg::OP_RD_ROOT;
              state_d  = S_ROOT_CMP;
            end
          end
          bmh_pkg::KIND_POP: begin
            if (stat_i.empty) begin
              cmd_o.status = bmh_pkg::ST_EMPTY;
              state_d      = S_RESP;
            end else begin
              cmd_o.op     = bmh_pkg::OP_RD_POP;
              cmd_o.status = bmh_pkg::ST_POPPED;
              state_d      = S_POP_TAKE;
            end
          end
          bmh_pkg::KIND_CLEAR: begin
            cmd_o.op     = bmh_pkg::OP_CLEAR;
            cmd_o.status = bmh_pkg::ST_CLEARED;
            state_d      = S_RESP;
          end
          bmh_pkg::KIND_RSVD: begin
            cmd_o.status = bmh_pkg::ST_REJECTED;
            state_d      = S_RESP;
          end
        endcase
      end
      S_UP_RD: begin
        if (stat_i.pos_zero) begin
          cmd_o.op = bmh_pkg::OP_PLACE;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = bmh_pkg::OP_RD_PARENT;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_gt) begin
          cmd_o.op = bmh_pkg::OP_UP_MOVE;
          state_d  = S_UP_RD;
        end else begin
          cmd_o.op = bmh_pkg::OP_PLACE;
          state_d  = S_RESP;
        end
      end
      S_ROOT_CMP: begin
        cmd_o.set_status = 1'b1;
        // replacement needs a strictly smaller distance than the root
        if (stat_i.root_lt) begin
          cmd_o.op     = bmh_pkg::OP_REPLACE;
          cmd_o.status = bmh_pkg::ST_REPLACED;
          state_d      = S_DN_RD;
        end else begin
          cmd_o.status = bmh_pkg::ST_REJECTED;
          state_d      = S_RESP;
        end
      end
      S_POP_TAKE: begin
        cmd_o.op = bmh_pkg::OP_POP_TAKE;
        state_d  = S_DN_RD;
      end
      S_DN_RD: begin
        cmd_o.op = bmh_pkg::OP_RD_KIDS;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_move) begin
          cmd_o.op = bmh_pkg::OP_DN_MOVE;
          state_d  = S_DN_RD;
        end else begin
          cmd_o.op = bmh_pkg::OP_PLACE;
          state_d  = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

endmodule

`default_nettype wire

// ----- tb/sv/bounded_max_heap_top_k_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_max_heap_top_k_top_tb
// Drives push, pop, clear and reserved beats into the top-k heap under
// random sender gaps and receiver stalls. A behavioral heap predicts every
// result, and each result beat is checked in order against it. Capacity is
// rewritten between queries, and the extremes are covered.
// ----------------------------------------------------------------------------
module bounded_max_heap_top_k_top_tb;
  import bmh_pkg::*;

  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    status_e              status;
    logic [DIST_W-1:0]    distance;
    logic [REC_W-1:0]     rec;
    logic [FILL_W-1:0]    fill;
  } heap_result_t;

  logic clk;
  logic rst_n;

  bmh_in_if  item_if ();
  bmh_out_if res_if ();
  bmh_cfg_if cfg_if ();

  bounded_max_heap_top_k_top dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // heap model state
  logic [DIST_W-1:0] slot_dist [MAX_NEIGHBOURS];
  logic [REC_W-1:0]  slot_rec  [MAX_NEIGHBOURS];
  int unsigned       held;
  logic [CFG_W-1:0]  capacity_reg;

  heap_result_t expected_results [$];
  int unsigned  items_sent;
  int unsigned  mismatch_count;
  int unsigned  burst_left;
  int unsigned  holdoff_left;
  int unsigned  stall_phase_left;
  int unsigned  stall_pct;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("bounded_max_heap_top_k_top_tb failed");
    $finish;
  end

  function automatic void exchange_slots(input int unsigned a, input int unsigned b);
    logic [DIST_W-1:0] d;
    logic [REC_W-1:0]  r;
    d = slot_dist[a];
    r = slot_rec[a];
    slot_dist[a] = slot_dist[b];
    slot_rec[a]  = slot_rec[b];
    slot_dist[b] = d;
    slot_rec[b]  = r;
  endfunction

  // sift the root down; the left child wins over an equal right child
  function automatic void settle_root();
    int unsigned pos;
    int unsigned big;
    int unsigned lc;
    int unsigned rc;
    bit          moving;
    pos    = 0;
    moving = 1'b1;
    while (moving && pos < held) begin
      big = pos;
      lc  = 2 * pos + 1;
      rc  = lc + 1;
      if (lc < held && slot_dist[lc] > slot_dist[big]) big = lc;
      if (rc < held && slot_dist[rc] > slot_dist[big]) big = rc;
      if (big == pos) begin
        moving = 1'b0;
      end else begin
        exchange_slots(pos, big);
        pos = big;
      end
    end
  endfunction

  function automatic heap_result_t apply_heap_op(input kind_e k, input logic [DIST_W-1:0] d,
                                                 input logic [REC_W-1:0] r);
    heap_result_t res;
    int unsigned  pos;
    int unsigned  cap;
    bit           rising;
    res.status   = ST_REJECTED;
    res.distance = '0;
    res.rec      = '0;
    cap = capacity_reg;
    if (cap == 0) cap = 1;
    if (cap > MAX_NEIGHBOURS) cap = MAX_NEIGHBOURS;
    case (k)
      KIND_PUSH: begin
        if (held < cap) begin
          slot_dist[held] = d;
          slot_rec[held]  = r;
          pos    = held;
          held   = held + 1;
          rising = 1'b1;
          while (rising && pos > 0) begin
            if (slot_dist[pos] <= slot_dist[(pos - 1) / 2]) begin
              rising = 1'b0;
            end else begin
              exchange_slots(pos, (pos - 1) / 2);
              pos = (pos - 1) / 2;
            end
          end
          res.status = ST_INSERTED;
        end else if (d < slot_dist[0]) begin
          // full heap (or capacity lowered below fill): replace the root
          slot_dist[0] = d;
          slot_rec[0]  = r;
          settle_root();
          res.status = ST_REPLACED;
        end
      end
      KIND_POP: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.distance = slot_dist[0];
          res.rec      = slot_rec[0];
          slot_dist[0] = slot_dist[held - 1];
          slot_rec[0]  = slot_rec[held - 1];
          held         = held - 1;
          settle_root();
          res.status = ST_POPPED;
        end
      end
      KIND_CLEAR: begin
        held       = 0;
        res.status = ST_CLEARED;
      end
      default: begin
      end
    endcase
    res.fill = FILL_W'(held);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DIST_W-1:0] got,
                                 input logic [DIST_W-1:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  // one beat on the item channel, in bursts separated by random gaps
  task automatic send_op(input kind_e k, input logic [DIST_W-1:0] d,
                         input logic [REC_W-1:0] r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_if.valid        <= 1'b1;
    item_if.kind         <= k;
    item_if.distance     <= d;
    item_if.record_index <= r;
    do @(posedge clk); while (!item_if.ready);
    expected_results.push_back(apply_heap_op(k, d, r));
    items_sent++;
    burst_left--;
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_if.valid           <= 1'b1;
    cfg_if.neighbour_count <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    capacity_reg = value;
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 3))
      0: return DIST_W'($urandom_range(0, 15));
      1: return DIST_W'($urandom);
      2: return ($urandom_range(0, 1) == 0) ? '0 : '1 - DIST_W'($urandom_range(0, 3));
      default: return DIST_W'($urandom_range(0, 1000));
    endcase
  endfunction

  // result ready: long holdoff on request, otherwise phases of random stalls
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      res_if.ready <= 1'b0;
      holdoff_left--;
    end else begin
      if (stall_phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 90;
        endcase
        stall_phase_left = $urandom_range(20, 200);
      end
      stall_phase_left--;
      res_if.ready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    heap_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", DIST_W'(res_if.status), '0);
      end else begin
        want = expected_results.pop_front();
        if (res_if.status !== want.status)
          report_mismatch("status", DIST_W'(res_if.status), DIST_W'(want.status));
        if (res_if.out_distance !== want.distance)
          report_mismatch("out_distance", res_if.out_distance, want.distance);
        if (res_if.out_record !== want.rec)
          report_mismatch("out_record", DIST_W'(res_if.out_record), DIST_W'(want.rec));
        if (res_if.fill_level !== want.fill)
          report_mismatch("fill_level", DIST_W'(res_if.fill_level), DIST_W'(want.fill));
      end
    end
  end

  // runs at the reset capacity of 16
  task automatic test_empty_and_extremes();
    send_op(KIND_POP, 32'h1234_5678, 16'h00ff);
    send_op(KIND_PUSH, '0, '0);
    send_op(KIND_PUSH, '1, '1);
    send_op(KIND_RSVD, '1, '1);
    send_op(KIND_POP, '0, '0);
    send_op(KIND_POP, '0, '0);
    send_op(KIND_POP, '0, '0);
    send_op(KIND_CLEAR, '1, '1);
  endtask

  task automatic test_capacity_edges();
    write_capacity(CFG_W'(1));
    send_op(KIND_PUSH, 32'd100, 16'd1);
    send_op(KIND_PUSH, 32'd100, 16'd2);   // equal to root: rejected
    send_op(KIND_PUSH, 32'd50, 16'd3);
    write_capacity(CFG_W'(0));             // behaves as one
    send_op(KIND_PUSH, 32'd3, 16'd4);
    send_op(KIND_POP, '0, '0);
    write_capacity(CFG_W'(31));            // clamps to the maximum
    send_op(KIND_PUSH, 32'd10, 16'd5);
    send_op(KIND_PUSH, 32'd20, 16'd6);
    send_op(KIND_PUSH, 32'd30, 16'd7);
    write_capacity(CFG_W'(2));             // now below the fill
    send_op(KIND_PUSH, 32'd5, 16'd8);
    send_op(KIND_POP, '0, '0);
    send_op(KIND_CLEAR, '0, '0);
  endtask

  task automatic test_sift_ties();
    write_capacity(CFG_W'(16));
    send_op(KIND_PUSH, 32'd9, 16'd1);
    send_op(KIND_PUSH, 32'd9, 16'd2);
    send_op(KIND_PUSH, 32'd9, 16'd3);
    send_op(KIND_POP, '0, '0);
    send_op(KIND_POP, '0, '0);
  endtask

  // queries: optional clear, pushes with stray pops, then a pop-out
  task automatic test_random_queries(input int unsigned count);
    int unsigned first;
    int unsigned pushes;
    int unsigned pops;
    logic [CFG_W-1:0] cap;
    first = items_sent;
    while (items_sent - first < count) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: cap = CFG_W'(1);
          1: cap = CFG_W'(16);
          2: cap = CFG_W'(0);
          3: cap = CFG_W'(31);
          4: cap = CFG_W'($urandom_range(17, 30));
          default: cap = CFG_W'($urandom_range(2, 15));
        endcase
        write_capacity(cap);
      end
      if ($urandom_range(0, 4) != 0) send_op(KIND_CLEAR, DIST_W'($urandom), REC_W'($urandom));
      pushes = $urandom_range(1, 40);
      repeat (pushes) begin
        if ($urandom_range(0, 6) == 0)
          send_op(KIND_POP, DIST_W'($urandom), REC_W'($urandom));
        else
          send_op(KIND_PUSH, pick_distance(), REC_W'($urandom));
      end
      pops = ($urandom_range(0, 2) == 0) ? $urandom_range(0, held) : held + $urandom_range(0, 2);
      repeat (pops) send_op(KIND_POP, DIST_W'($urandom), REC_W'($urandom));
    end
  endtask

  task automatic test_result_backpressure();
    holdoff_left = 300;
    repeat (24) begin
      if ($urandom_range(0, 3) == 0)
        send_op(KIND_POP, DIST_W'($urandom), REC_W'($urandom));
      else
        send_op(KIND_PUSH, pick_distance(), REC_W'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_noise(input int unsigned count);
    repeat (count)
      send_op(kind_e'($urandom_range(0, 3)), pick_distance(), REC_W'($urandom));
  endtask

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    item_if.valid          = 1'b0;
    item_if.kind           = KIND_PUSH;
    item_if.distance       = '0;
    item_if.record_index   = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.neighbour_count = '0;
    res_if.ready           = 1'b0;
    held                   = 0;
    capacity_reg           = CFG_RESET;
    items_sent             = 0;
    mismatch_count         = 0;
    burst_left             = 0;
    holdoff_left           = 0;
    stall_phase_left       = 0;
    stall_pct              = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_extremes();
    test_capacity_edges();
    test_sift_ties();
    test_random_queries(1550);
    test_result_backpressure();
    test_noise(250);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("bounded_max_heap_top_k_top_tb passed");
    end else begin
      $display("bounded_max_heap_top_k_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- bounded_max_heap_top_k_top.f -----
+incdir+src
src/bmh_pkg.sv
src/bmh_in_if.sv
src/bmh_out_if.sv
src/bmh_cfg_if.sv
src/bmh_datapath.sv
src/bmh_ctrl.sv
src/bounded_max_heap_top_k_top.sv
tb/sv/bounded_max_heap_top_k_top_tb.sv
